@@ src/bclf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclf_pkg
// Shared types, widths, register codes and the quarter-sine brightness table
// of the battery charge LED fade block.
// ----------------------------------------------------------------------------
package bclf_pkg;

  localparam int FRAME_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

  localparam int LEN_W     = 16;
  localparam int FADE_W    = 15;
  localparam int LEVEL_W   = 11;
  localparam int HUE_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int BR_W      = 11;
  localparam int FRAC_W    = 10;
  localparam int POS_W     = ((FRAME_BITS > LEN_W) ? FRAME_BITS : LEN_W) + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 11'd1024;
  localparam logic [BR_W-1:0]    BR_ONE     = 11'd1024;
  localparam logic [HUE_W-1:0]   HUE_LIMIT  = 9'd360;

  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam int          TAYLOR_TERMS = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANIM_LENGTH   = 3'd0,
    REG_FADE_FRAMES   = 3'd1,
    REG_BATTERY_LEVEL = 3'd2,
    REG_HUE_MIN       = 3'd3,
    REG_HUE_MAX       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]   anim_length;
    logic [FADE_W-1:0]  fade_frames;
    logic [LEVEL_W-1:0] battery_level;
    logic [HUE_W-1:0]   hue_min;
    logic [HUE_W-1:0]   hue_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    anim_length:   16'd100,
    fade_frames:   15'd10,
    battery_level: 11'd0,
    hue_min:       9'd0,
    hue_max:       9'd120
  };

  typedef enum logic [1:0] {
    BR_DARK,
    BR_FULL,
    BR_FADE
  } br_mode_t;

  typedef struct packed {
    br_mode_t           mode;
    logic [FADE_W-1:0]  offset;
    logic [FADE_W-1:0]  fade;
  } win_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][BR_W-1:0] sine_lut_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] level);
    return (level > LEVEL_FULL) ? LEVEL_FULL : level;
  endfunction

  // Quarter sine in Q1.10, evaluated at elaboration with a Q30 Taylor series.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    lut = '0;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1: begin
            term = term / 6;
          end
          2: begin
            term = term / 20;
          end
          3: begin
            term = term / 42;
          end
          4: begin
            term = term / 72;
          end
          5: begin
            term = term / 110;
          end
          default: begin
            term = term / 156;
          end
        endcase
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      lut[k] = BR_W'((sum + (64'd1 << 19)) >> 20);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage
`default_nettype wire

@@ src/battery_charge_led_fade.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_charge_led_fade
// Color of every LED in one frame of a battery charge animation.
// ----------------------------------------------------------------------------
// The block accepts one frame index per clock while the pipeline advances and
// returns its red, green and blue levels: four stages place the on-window, eight
// stages of a one-bit-per-stage divider form the sine table index, and two stages
// look up the brightness and scale the color into the output register. The
// whole pipeline advances whenever the output register is empty or being
// taken, so a stalled result holds every item behind it in place. Settings
// written on the configuration port apply to every item accepted after the
// write; write them only while no item is in flight.
module battery_charge_led_fade (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bclf_pkg::FRAME_BITS-1:0]    in_frame_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bclf_pkg::CHAN_W-1:0]        out_red,
  output logic [bclf_pkg::CHAN_W-1:0]        out_green,
  output logic [bclf_pkg::CHAN_W-1:0]        out_blue,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bclf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bclf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bclf_pkg::cfg_t       cfg_r;
  logic                 adv;
  logic                 win_valid;
  bclf_pkg::win_item_t  win;
  logic                 div_valid;
  bclf_pkg::br_mode_t   div_mode;
  logic [bclf_pkg::IDX_W-1:0] div_idx;
  bclf_pkg::rgb_t       color;
  bclf_pkg::rgb_t       pix;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bclf_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bclf_pkg::REG_ANIM_LENGTH: begin
          cfg_r.anim_length <= cfg_data[bclf_pkg::LEN_W-1:0];
        end
        bclf_pkg::REG_FADE_FRAMES: begin
          cfg_r.fade_frames <= cfg_data[bclf_pkg::FADE_W-1:0];
        end
        bclf_pkg::REG_BATTERY_LEVEL: begin
          cfg_r.battery_level <= cfg_data[bclf_pkg::LEVEL_W-1:0];
        end
        bclf_pkg::REG_HUE_MIN: begin
          cfg_r.hue_min <= cfg_data[bclf_pkg::HUE_W-1:0];
        end
        bclf_pkg::REG_HUE_MAX: begin
          cfg_r.hue_max <= cfg_data[bclf_pkg::HUE_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  bclf_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .frame     (in_frame_index),
    .cfg       (cfg_r),
    .win_valid (win_valid),
    .win       (win)
  );

  bclf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (win_valid),
    .win       (win),
    .out_valid (div_valid),
    .out_mode  (div_mode),
    .out_idx   (div_idx)
  );

  bclf_hue u_hue (
    .clk   (clk),
    .cfg   (cfg_r),
    .color (color)
  );

  bclf_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (div_valid),
    .mode      (div_mode),
    .idx       (div_idx),
    .color     (color),
    .out_valid (out_valid),
    .pix       (pix)
  );

  assign out_red   = pix.red;
  assign out_green = pix.green;
  assign out_blue  = pix.blue;

endmodule
`default_nettype wire

@@ src/bclf_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclf_window
// Four-stage pipeline that places the centered on-window in the cycle and
// classifies each frame as dark, fully lit or inside a fade.
// ----------------------------------------------------------------------------
module bclf_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [bclf_pkg::FRAME_BITS-1:0]  frame,
  input  bclf_pkg::cfg_t                   cfg,
  output logic                             win_valid,
  output bclf_pkg::win_item_t              win
);

  localparam int PROD_W = bclf_pkg::LEN_W + bclf_pkg::LEVEL_W;
  localparam int ON_W   = PROD_W - bclf_pkg::FRAC_W;
  localparam int LEN_W  = bclf_pkg::LEN_W;
  localparam int FADE_W = bclf_pkg::FADE_W;
  localparam int POS_W  = bclf_pkg::POS_W;

  logic                            v1_r;
  logic [bclf_pkg::FRAME_BITS-1:0] frame1_r;
  logic [PROD_W-1:0]               prod1_r;
  logic [PROD_W-1:0]               prod1_nxt;

  logic                            v2_r;
  logic [bclf_pkg::FRAME_BITS-1:0] frame2_r;
  logic [LEN_W-1:0]                on2_r;
  logic [LEN_W-1:0]                on2_nxt;
  logic [FADE_W-1:0]               fade2_r;
  logic [FADE_W-1:0]               fade2_nxt;

  logic                            v3_r;
  logic [bclf_pkg::FRAME_BITS-1:0] frame3_r;
  logic [LEN_W-1:0]                start3_r;
  logic [LEN_W-1:0]                start3_nxt;
  logic [LEN_W-1:0]                end3_r;
  logic [LEN_W-1:0]                end3_nxt;
  logic [FADE_W-1:0]               fade3_r;

  logic                            win_valid_r;
  bclf_pkg::win_item_t             win_r;
  bclf_pkg::win_item_t             win_nxt;

  logic [PROD_W-1:0] round_sum;
  logic [ON_W-1:0]   on_q;
  logic [ON_W-1:0]   on_min;
  logic [ON_W-1:0]   on_a;
  logic [LEN_W:0]    end_sum;
  logic [POS_W-1:0]  frame_p;
  logic [POS_W-1:0]  start_p;
  logic [POS_W-1:0]  end_p;
  logic [POS_W-1:0]  fade_p;
  logic [POS_W-1:0]  lim_in;
  logic [POS_W-1:0]  lim_out;
  logic [POS_W-1:0]  diff_in;
  logic [POS_W-1:0]  diff_out;

  always_comb begin
    prod1_nxt = PROD_W'(cfg.anim_length)
              * PROD_W'(bclf_pkg::clamp_level(cfg.battery_level));
  end

  always_comb begin
    round_sum = prod1_r + PROD_W'(1 << (bclf_pkg::FRAC_W - 1));
    on_q      = round_sum[PROD_W-1:bclf_pkg::FRAC_W];
    on_min    = ON_W'({cfg.fade_frames, 1'b0});
    on_a      = (on_q < on_min) ? on_min : on_q;
    if (on_a >= ON_W'(cfg.anim_length)) begin
      on2_nxt   = cfg.anim_length;
      fade2_nxt = '0;
    end else begin
      on2_nxt   = on_a[LEN_W-1:0];
      fade2_nxt = cfg.fade_frames;
    end
  end

  always_comb begin
    start3_nxt = (cfg.anim_length - on2_r) >> 1;
    end_sum    = {1'b0, cfg.anim_length} + {1'b0, on2_r};
    end3_nxt   = end_sum[LEN_W:1];
  end

  always_comb begin
    frame_p  = POS_W'(frame3_r);
    start_p  = POS_W'(start3_r);
    end_p    = POS_W'(end3_r);
    fade_p   = POS_W'(fade3_r);
    lim_in   = start_p + fade_p;
    lim_out  = end_p - fade_p;
    diff_in  = frame_p - start_p;
    diff_out = end_p - frame_p;
    win_nxt.fade = fade3_r;
    if (frame_p < start_p) begin
      win_nxt.mode   = bclf_pkg::BR_DARK;
      win_nxt.offset = '0;
    end else if (frame_p < lim_in) begin
      win_nxt.mode   = bclf_pkg::BR_FADE;
      win_nxt.offset = diff_in[FADE_W-1:0];
    end else if (frame_p <= lim_out) begin
      win_nxt.mode   = bclf_pkg::BR_FULL;
      win_nxt.offset = '0;
    end else if (frame_p < end_p) begin
      win_nxt.mode   = bclf_pkg::BR_FADE;
      win_nxt.offset = diff_out[FADE_W-1:0];
    end else begin
      win_nxt.mode   = bclf_pkg::BR_DARK;
      win_nxt.offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      win_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      win_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame1_r <= frame;
      prod1_r  <= prod1_nxt;
      frame2_r <= frame1_r;
      on2_r    <= on2_nxt;
      fade2_r  <= fade2_nxt;
      frame3_r <= frame2_r;
      start3_r <= start3_nxt;
      end3_r   <= end3_nxt;
      fade3_r  <= fade2_r;
      win_r    <= win_nxt;
    end
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;

  a_window_covers_fades: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (ON_W'(on2_r) >= ON_W'({fade2_r, 1'b0})))
    else $error("on-window shorter than both fades");

  a_fade_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (win_valid_r && (win_r.mode == bclf_pkg::BR_FADE)) |-> (win_r.offset < win_r.fade))
    else $error("fade offset not below fade length");

endmodule
`default_nettype wire

@@ src/bclf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclf_div
// Pipelined restoring divider: one quotient bit per stage gives the sine
// table index (distance * depth) / fade for items inside a fade.
// ----------------------------------------------------------------------------
module bclf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  bclf_pkg::win_item_t          win,
  output logic                         out_valid,
  output bclf_pkg::br_mode_t           out_mode,
  output logic [bclf_pkg::IDX_W-1:0]   out_idx
);

  localparam int IDX_W  = bclf_pkg::IDX_W;
  localparam int FADE_W = bclf_pkg::FADE_W;

  logic               v_r    [IDX_W];
  bclf_pkg::br_mode_t mode_r [IDX_W];
  logic [FADE_W:0]    rem_r  [IDX_W];
  logic [FADE_W-1:0]  fade_r [IDX_W];
  logic [IDX_W-1:0]   quot_r [IDX_W];

  for (genvar i = 0; i < IDX_W; i++) begin : g_step
    logic               v_in;
    bclf_pkg::br_mode_t mode_in;
    logic [FADE_W:0]    rem_in;
    logic [FADE_W-1:0]  fade_in;
    logic [IDX_W-1:0]   quot_in;
    logic [FADE_W:0]    shifted;
    logic               take;
    logic [FADE_W:0]    rem_nxt;
    logic [IDX_W-1:0]   quot_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign mode_in = win.mode;
      assign rem_in  = {1'b0, win.offset};
      assign fade_in = win.fade;
      assign quot_in = '0;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign mode_in = mode_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign fade_in = fade_r[i-1];
      assign quot_in = quot_r[i-1];
    end

    always_comb begin
      shifted  = {rem_in[FADE_W-1:0], 1'b0};
      take     = (shifted >= {1'b0, fade_in});
      rem_nxt  = take ? (shifted - {1'b0, fade_in}) : shifted;
      quot_nxt = {quot_in[IDX_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mode_r[i] <= mode_in;
        rem_r[i]  <= rem_nxt;
        fade_r[i] <= fade_in;
        quot_r[i] <= quot_nxt;
      end
    end
  end

  assign out_valid = v_r[IDX_W-1];
  assign out_mode  = mode_r[IDX_W-1];
  assign out_idx   = quot_r[IDX_W-1];

  a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[IDX_W-1] && (mode_r[IDX_W-1] == bclf_pkg::BR_FADE))
      |-> (rem_r[IDX_W-1] < {1'b0, fade_r[IDX_W-1]}))
    else $error("divider remainder not below fade length");

endmodule
`default_nettype wire

@@ src/bclf_hue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclf_hue
// Six-stage pipeline that turns the battery level and hue limits into a
// fully saturated, full-value RGB color.
// ----------------------------------------------------------------------------
module bclf_hue (
  input  logic            clk,
  input  bclf_pkg::cfg_t  cfg,
  output bclf_pkg::rgb_t  color
);

  localparam int HUE_W    = bclf_pkg::HUE_W;
  localparam int LEVEL_W  = bclf_pkg::LEVEL_W;
  localparam int CHAN_W   = bclf_pkg::CHAN_W;
  localparam int HD_W     = HUE_W + LEVEL_W + 2;
  localparam int HPOS_W   = HUE_W + bclf_pkg::FRAC_W;
  localparam int REM_W    = 16;
  localparam int SCALED_W = 24;
  localparam int Y_W      = 12;

  localparam int                 NUM_SECTORS  = 6;
  localparam logic [HPOS_W-1:0]  HUE_SECTOR   = 19'd61440;
  localparam logic [CHAN_W-1:0]  CHAN_MAX     = 8'd255;
  localparam int                 SECTOR_SHIFT = 12;
  localparam logic [SCALED_W-1:0] RECIP_15    = 24'd4370;
  localparam int                 RECIP_SHIFT  = 16;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  logic signed [HD_W-1:0] hd1_r;
  logic signed [HD_W-1:0] hd1_nxt;
  logic [HUE_W-1:0]       hmin1_r;
  logic [HUE_W-1:0]       hmin1_nxt;
  logic [HPOS_W-1:0]      hue2_r;
  logic [HPOS_W-1:0]      hue2_nxt;
  sector_t                sector3_r;
  sector_t                sector3_nxt;
  logic [REM_W-1:0]       rem3_r;
  logic [REM_W-1:0]       rem3_nxt;
  sector_t                sector4_r;
  logic [Y_W-1:0]         yt4_r;
  logic [Y_W-1:0]         yt4_nxt;
  logic [Y_W-1:0]         yq4_r;
  logic [Y_W-1:0]         yq4_nxt;
  sector_t                sector5_r;
  logic [CHAN_W-1:0]      t5_r;
  logic [CHAN_W-1:0]      t5_nxt;
  logic [CHAN_W-1:0]      q5_r;
  logic [CHAN_W-1:0]      q5_nxt;
  bclf_pkg::rgb_t         color_r;
  bclf_pkg::rgb_t         color_nxt;

  logic [HUE_W-1:0]        hmax_c;
  logic signed [HUE_W:0]   span;
  logic [LEVEL_W-1:0]      level;
  logic signed [HD_W-1:0]  base;
  logic signed [HD_W-1:0]  hue_sum;
  logic [2:0]              cnt;
  logic [HPOS_W-1:0]       sub;
  logic [HPOS_W-1:0]       diff;
  logic [SCALED_W-1:0]     xt;
  logic [SCALED_W-1:0]     xq;
  logic [REM_W-1:0]        rem_q;
  logic [SCALED_W-1:0]     pt;
  logic [SCALED_W-1:0]     pq;

  always_comb begin
    level     = bclf_pkg::clamp_level(cfg.battery_level);
    hmin1_nxt = (cfg.hue_min > bclf_pkg::HUE_LIMIT) ? bclf_pkg::HUE_LIMIT : cfg.hue_min;
    hmax_c    = (cfg.hue_max > bclf_pkg::HUE_LIMIT) ? bclf_pkg::HUE_LIMIT : cfg.hue_max;
    span      = $signed({1'b0, hmax_c}) - $signed({1'b0, hmin1_nxt});
    hd1_nxt   = HD_W'(span) * HD_W'($signed({1'b0, level}));
  end

  always_comb begin
    base     = $signed(HD_W'({hmin1_r, {bclf_pkg::FRAC_W{1'b0}}}));
    hue_sum  = base + hd1_r;
    hue2_nxt = hue_sum[HPOS_W-1:0];
  end

  always_comb begin
    cnt = '0;
    for (int k = 1; k <= NUM_SECTORS; k++) begin
      cnt = cnt + 3'(hue2_r >= HPOS_W'(k * 61440));
    end
    sub      = HPOS_W'(cnt) * HUE_SECTOR;
    diff     = hue2_r - sub;
    rem3_nxt = diff[REM_W-1:0];
    if (cnt >= 3'(NUM_SECTORS)) begin
      sector3_nxt = SEC_RED_YELLOW;
    end else begin
      sector3_nxt = sector_t'(cnt);
    end
  end

  always_comb begin
    rem_q   = HUE_SECTOR[REM_W-1:0] - rem3_r;
    xt      = SCALED_W'(rem3_r) * SCALED_W'(CHAN_MAX);
    xq      = SCALED_W'(rem_q) * SCALED_W'(CHAN_MAX);
    yt4_nxt = xt[SECTOR_SHIFT+Y_W-1:SECTOR_SHIFT];
    yq4_nxt = xq[SECTOR_SHIFT+Y_W-1:SECTOR_SHIFT];
  end

  always_comb begin
    pt     = SCALED_W'(yt4_r) * RECIP_15;
    pq     = SCALED_W'(yq4_r) * RECIP_15;
    t5_nxt = pt[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    q5_nxt = pq[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
  end

  always_comb begin
    case (sector5_r)
      SEC_RED_YELLOW: begin
        color_nxt = '{red: CHAN_MAX, green: t5_r, blue: '0};
      end
      SEC_YELLOW_GREEN: begin
        color_nxt = '{red: q5_r, green: CHAN_MAX, blue: '0};
      end
      SEC_GREEN_CYAN: begin
        color_nxt = '{red: '0, green: CHAN_MAX, blue: t5_r};
      end
      SEC_CYAN_BLUE: begin
        color_nxt = '{red: '0, green: q5_r, blue: CHAN_MAX};
      end
      SEC_BLUE_MAGENTA: begin
        color_nxt = '{red: t5_r, green: '0, blue: CHAN_MAX};
      end
      default: begin
        color_nxt = '{red: CHAN_MAX, green: '0, blue: q5_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hd1_r     <= hd1_nxt;
    hmin1_r   <= hmin1_nxt;
    hue2_r    <= hue2_nxt;
    sector3_r <= sector3_nxt;
    rem3_r    <= rem3_nxt;
    sector4_r <= sector3_r;
    yt4_r     <= yt4_nxt;
    yq4_r     <= yq4_nxt;
    sector5_r <= sector4_r;
    t5_r      <= t5_nxt;
    q5_r      <= q5_nxt;
    color_r   <= color_nxt;
  end

  assign color = color_r;

endmodule
`default_nettype wire

@@ src/bclf_shade.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclf_shade
// Looks up the fade brightness in the quarter-sine table and scales the
// color by it into the output register.
// ----------------------------------------------------------------------------
module bclf_shade (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  bclf_pkg::br_mode_t          mode,
  input  logic [bclf_pkg::IDX_W-1:0]  idx,
  input  bclf_pkg::rgb_t              color,
  output logic                        out_valid,
  output bclf_pkg::rgb_t              pix
);

  localparam int CHAN_W = bclf_pkg::CHAN_W;
  localparam int BR_W   = bclf_pkg::BR_W;
  localparam int PROD_W = CHAN_W + BR_W;
  localparam int FRAC_W = bclf_pkg::FRAC_W;

  logic              va_r;
  logic [BR_W-1:0]   br_a_r;
  logic [BR_W-1:0]   br_a_nxt;
  logic              out_valid_r;
  bclf_pkg::rgb_t    pix_r;
  bclf_pkg::rgb_t    pix_nxt;

  function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                              input logic [BR_W-1:0] br);
    logic [PROD_W-1:0] p;
    p = PROD_W'(c) * PROD_W'(br);
    return p[FRAC_W+CHAN_W-1:FRAC_W];
  endfunction

  always_comb begin
    case (mode)
      bclf_pkg::BR_FULL: begin
        br_a_nxt = bclf_pkg::BR_ONE;
      end
      bclf_pkg::BR_FADE: begin
        br_a_nxt = bclf_pkg::SINE_LUT[idx];
      end
      default: begin
        br_a_nxt = '0;
      end
    endcase
  end

  always_comb begin
    pix_nxt.red   = scale(color.red, br_a_r);
    pix_nxt.green = scale(color.green, br_a_r);
    pix_nxt.blue  = scale(color.blue, br_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= in_valid;
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br_a_r <= br_a_nxt;
      pix_r  <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign pix       = pix_r;

endmodule
`default_nettype wire
